>>> hdl/decimal_divide_round_assert.svh
// Assertion macros for the scaled decimal divider.
// Each check is sampled on i_clk and disabled while i_rst_n is low.
`ifndef DECIMAL_DIVIDE_ROUND_ASSERT_SVH
`define DECIMAL_DIVIDE_ROUND_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DDR_ASSERT_NOW(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);
`define DDR_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define DDR_ASSERT_NOW(lbl, cond, expr, msg)
`define DDR_ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

>>> hdl/ddr_pkg.sv
package ddr_pkg;

    localparam int DEF_SIG_WIDTH   = 64;
    localparam int DEF_SCALE_RANGE = 64;

    typedef enum logic [2:0] {
        RM_UP        = 3'd0,
        RM_DOWN      = 3'd1,
        RM_CEILING   = 3'd2,
        RM_FLOOR     = 3'd3,
        RM_HALF_UP   = 3'd4,
        RM_HALF_DOWN = 3'd5,
        RM_HALF_EVEN = 3'd6,
        RM_UNNEC     = 3'd7
    } t_round_mode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_INEXACT  = 2'd3
    } t_status;

    // Whether the truncated magnitude is to be bumped by one unit.
    function automatic logic round_inc(t_round_mode mode, logic nz, logic gt, logic eq,
                                       logic neg, logic odd);
        logic inc;
        inc = 1'b0;
        unique case (mode)
            RM_UP:        inc = nz;
            RM_DOWN:      inc = 1'b0;
            RM_CEILING:   inc = nz && !neg;
            RM_FLOOR:     inc = nz && neg;
            RM_HALF_UP:   inc = gt || eq;
            RM_HALF_DOWN: inc = gt;
            RM_HALF_EVEN: inc = gt || (eq && odd);
            default:      inc = 1'b0;
        endcase
        return inc;
    endfunction

endpackage

>>> hdl/ddr_divider.sv
module ddr_divider #(
    parameter int SIG_WIDTH = ddr_pkg::DEF_SIG_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SIG_WIDTH-1:0] i_dividend,
    input  logic [SIG_WIDTH-1:0] i_divisor,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [SIG_WIDTH-1:0] o_quotient,
    output logic [SIG_WIDTH-1:0] o_remainder
);

    localparam int CW = $clog2(SIG_WIDTH + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [SIG_WIDTH-1:0] r_quo;
    logic [SIG_WIDTH-1:0] r_rem;
    logic [SIG_WIDTH-1:0] r_div;

    logic [SIG_WIDTH:0]   trial;
    logic [SIG_WIDTH:0]   diff;
    logic                 ge;
    logic [SIG_WIDTH-1:0] n_rem;
    logic [SIG_WIDTH-1:0] n_quo;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        trial = {r_rem, r_quo[SIG_WIDTH-1]};
        diff  = trial - {1'b0, r_div};
        ge    = !diff[SIG_WIDTH];
        n_rem = ge ? diff[SIG_WIDTH-1:0] : trial[SIG_WIDTH-1:0];
        n_quo = {r_quo[SIG_WIDTH-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SIG_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> hdl/ddr_scale_up.sv
module ddr_scale_up #(
    parameter int SIG_WIDTH = ddr_pkg::DEF_SIG_WIDTH,
    parameter int CW        = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SIG_WIDTH-1:0] i_value,
    input  logic [CW-1:0]        i_steps,
    input  logic                 i_neg,
    output logic                 o_done,
    output logic                 o_overflow,
    output logic [SIG_WIDTH-1:0] o_value
);

    localparam logic [SIG_WIDTH-1:0] NEGMAX  = {1'b1, {(SIG_WIDTH-1){1'b0}}};
    localparam logic [SIG_WIDTH-1:0] NEG_D10 = SIG_WIDTH'(NEGMAX / 10);
    localparam logic [SIG_WIDTH-1:0] POS_D10 = SIG_WIDTH'((NEGMAX - 1'b1) / 10);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_ovf;
    logic [CW-1:0]        r_cnt;
    logic [SIG_WIDTH-1:0] r_v;
    logic [SIG_WIDTH-1:0] r_limd;

    logic                 over;
    logic [SIG_WIDTH+3:0] mul10;

    // Each step checks that one more decimal digit still fits, then appends it.
    always_comb begin
        over  = r_v > r_limd;
        mul10 = {1'b0, r_v, 3'b000} + {3'b000, r_v, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
                r_ovf  <= 1'b0;
            end else if (r_busy) begin
                if (over) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_ovf  <= 1'b1;
                end else if (r_v == '0 || r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_limd <= i_neg ? NEG_D10 : POS_D10;
        end else if (r_busy && !over && r_v != '0 && r_cnt != CW'(1)) begin
            r_v <= mul10[SIG_WIDTH-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_overflow = r_ovf;
    assign o_value    = r_v;

endmodule

>>> hdl/decimal_divide_round.sv
// Scaled decimal divider with rounding. Each beat on the slave side carries two
// scaled decimals and a requested result scale; the block returns their quotient
// at that scale, rounded by one of eight modes, with a status code, as one beat
// on the master side. Throughput is one item at a time. An item that scales up
// runs the multiply-by-ten loop, which appends up to e decimal digits (e being
// the result scale less the dividend scale plus the divisor scale), then the
// bit-serial divider, then control and rounding. An item that scales down
// takes the divider pass for the quotient and then one further divider pass,
// by ten, for each dropped decimal digit while the running quotient is nonzero,
// so at most about twenty passes for 64 bits. The next item is accepted once
// the previous result has been placed in the output register, even if that
// result has not yet been taken.
`include "decimal_divide_round_assert.svh"

module decimal_divide_round #(
    parameter int SIG_WIDTH   = ddr_pkg::DEF_SIG_WIDTH,
    parameter int SCALE_RANGE = ddr_pkg::DEF_SCALE_RANGE
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // Fields from bit 0: dividend_sig[63:0], dividend_scale[71:64],
    // divisor_sig[135:72], divisor_scale[143:136], result_scale[151:144],
    // round_mode[154:152], zero padding[159:155].
    input  logic [159:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // Fields from bit 0: quotient_sig[63:0], quotient_scale[71:64],
    // status[73:72], zero padding[79:74].
    output logic [79:0]  o_m_axis_tdata
);

    import ddr_pkg::*;

    // Width of the combined scale exponent and of the step counters.
    localparam int EW = $clog2(3 * SCALE_RANGE + 2) + 1;
    localparam int CW = EW - 1;
    localparam logic signed [7:0]   RMAX   = 8'(SCALE_RANGE);
    localparam logic [SIG_WIDTH:0]  NEGMAX = {2'b01, {(SIG_WIDTH-1){1'b0}}};
    localparam logic [SIG_WIDTH:0]  POSMAX = NEGMAX - 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_SCALE = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_DCHK  = 8'b0001_0000,
        S_DROP  = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    function automatic logic signed [7:0] clamp_scale(logic signed [7:0] s);
        logic signed [7:0] c;
        c = s;
        if (s > RMAX)  c = RMAX;
        if (s < -RMAX) c = -RMAX;
        return c;
    endfunction

    t_state                r_state;
    logic [SIG_WIDTH-1:0]  r_ma;
    logic [SIG_WIDTH-1:0]  r_mb;
    logic                  r_na;
    logic                  r_nb;
    logic signed [7:0]     r_t;
    logic signed [EW-1:0]  r_e;
    t_round_mode           r_mode;
    logic                  r_up;
    logic [SIG_WIDTH-1:0]  r_q;
    logic [SIG_WIDTH:0]    r_qi;
    logic [3:0]            r_rd;
    logic                  r_sticky;
    logic                  r_nz;
    logic                  r_gt;
    logic                  r_eq;
    logic [CW-1:0]         r_cnt;
    t_status               r_status;
    logic                  r_ov;
    logic [63:0]           r_osig;
    logic signed [7:0]     r_oscale;
    t_status               r_ostat;

    logic                  in_acc;
    logic                  out_free;
    logic [SIG_WIDTH-1:0]  a_raw;
    logic [SIG_WIDTH-1:0]  b_raw;
    logic [SIG_WIDTH-1:0]  a_mag;
    logic [SIG_WIDTH-1:0]  b_mag;
    logic signed [7:0]     s1_c;
    logic signed [7:0]     s2_c;
    logic signed [7:0]     t_c;
    logic signed [EW-1:0]  e_w;

    logic                  div_start;
    logic [SIG_WIDTH-1:0]  div_dividend;
    logic [SIG_WIDTH-1:0]  div_divisor;
    logic                  div_busy;
    logic                  div_done;
    logic [SIG_WIDTH-1:0]  div_quo;
    logic [SIG_WIDTH-1:0]  div_rem;

    logic                  su_start;
    logic                  su_done;
    logic                  su_ovf;
    logic [SIG_WIDTH-1:0]  su_value;

    logic                  drop_end;
    logic                  inc;
    logic                  neg;
    logic [SIG_WIDTH:0]    q_sat;
    logic [SIG_WIDTH-1:0]  sig_w;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // Significands come from their SIG_WIDTH-bit fields, held as sign and magnitude.
    always_comb begin
        a_raw = i_s_axis_tdata[SIG_WIDTH-1:0];
        b_raw = i_s_axis_tdata[72 +: SIG_WIDTH];
        a_mag = a_raw[SIG_WIDTH-1] ? (~a_raw + 1'b1) : a_raw;
        b_mag = b_raw[SIG_WIDTH-1] ? (~b_raw + 1'b1) : b_raw;
        s1_c  = clamp_scale(i_s_axis_tdata[71:64]);
        s2_c  = clamp_scale(i_s_axis_tdata[143:136]);
        t_c   = clamp_scale(i_s_axis_tdata[151:144]);
        e_w   = EW'(t_c) - EW'(s1_c) + EW'(s2_c);
    end

    // The digit drop ends when the count runs out, or when both the quotient and
    // the last digit are zero, since nothing further would change.
    assign drop_end = (r_cnt == '0) || (r_q == '0 && r_rd == 4'd0);

    assign neg = r_na ^ r_nb;
    assign inc = round_inc(r_mode, r_nz, r_gt, r_eq, neg, r_q[0]);

    // Saturate the rounded magnitude, then apply the sign.
    always_comb begin
        if (neg) begin
            q_sat = (r_qi > NEGMAX) ? NEGMAX : r_qi;
            sig_w = ~q_sat[SIG_WIDTH-1:0] + 1'b1;
        end else begin
            q_sat = (r_qi > POSMAX) ? POSMAX : r_qi;
            sig_w = q_sat[SIG_WIDTH-1:0];
        end
    end

    // The one divider serves the main division and every divide-by-ten.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_ma;
        div_divisor  = r_mb;
        su_start     = 1'b0;
        unique case (r_state)
            S_CHECK: begin
                if (r_mb != '0) begin
                    if (r_e >= 0) su_start  = 1'b1;
                    else          div_start = 1'b1;
                end
            end
            S_SCALE: begin
                div_dividend = su_value;
                div_start    = su_done && !su_ovf;
            end
            S_DCHK: begin
                div_dividend = r_q;
                div_divisor  = SIG_WIDTH'(10);
                div_start    = !drop_end;
            end
            default: begin
            end
        endcase
    end

    ddr_scale_up #(
        .SIG_WIDTH (SIG_WIDTH),
        .CW        (CW)
    ) u_scale_up (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (su_start),
        .i_value    (r_ma),
        .i_steps    (CW'(r_e) + 1'b1),
        .i_neg      (r_na),
        .o_done     (su_done),
        .o_overflow (su_ovf),
        .o_value    (su_value)
    );

    ddr_divider #(
        .SIG_WIDTH (SIG_WIDTH)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // A new result fills the output register; otherwise a taken beat empties it.
            if (r_state == S_OUT && out_free) r_ov <= 1'b1;
            else if (i_m_axis_tready)         r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE:  if (in_acc) r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_mb == '0)    r_state <= S_OUT;
                    else if (r_e >= 0) r_state <= S_SCALE;
                    else               r_state <= S_DIV;
                end
                S_SCALE: begin
                    if (su_done) r_state <= su_ovf ? S_OUT : S_DIV;
                end
                S_DIV:   if (div_done) r_state <= r_up ? S_ROUND : S_DCHK;
                S_DCHK:  r_state <= drop_end ? S_ROUND : S_DROP;
                S_DROP:  if (div_done) r_state <= S_DCHK;
                S_ROUND: r_state <= S_OUT;
                S_OUT:   if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_ma   <= a_mag;
                    r_mb   <= b_mag;
                    r_na   <= a_raw[SIG_WIDTH-1];
                    r_nb   <= b_raw[SIG_WIDTH-1];
                    r_t    <= t_c;
                    r_e    <= e_w;
                    r_mode <= t_round_mode'(i_s_axis_tdata[154:152]);
                end
            end
            S_CHECK: begin
                r_up <= (r_e >= 0);
                if (r_mb == '0) r_status <= ST_DIVZERO;
            end
            S_SCALE: begin
                if (su_done && su_ovf) r_status <= ST_OVERFLOW;
            end
            S_DIV: begin
                if (div_done) begin
                    r_q <= div_quo;
                    if (r_up) begin
                        r_nz <= (div_rem != '0);
                        r_gt <= ({div_rem, 1'b0} > {1'b0, r_mb});
                        r_eq <= ({div_rem, 1'b0} == {1'b0, r_mb});
                    end else begin
                        r_sticky <= (div_rem != '0);
                        r_rd     <= 4'd0;
                        r_cnt    <= CW'(-r_e);
                    end
                end
            end
            S_DCHK: begin
                if (drop_end) begin
                    r_nz <= (r_rd != 4'd0) || r_sticky;
                    r_gt <= (r_rd > 4'd5) || (r_rd == 4'd5 && r_sticky);
                    r_eq <= (r_rd == 4'd5) && !r_sticky;
                end else begin
                    if (r_rd != 4'd0) r_sticky <= 1'b1;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            S_DROP: begin
                if (div_done) begin
                    r_q  <= div_quo;
                    r_rd <= div_rem[3:0];
                end
            end
            S_ROUND: begin
                if (r_mode == RM_UNNEC && r_nz) begin
                    r_status <= ST_INEXACT;
                end else begin
                    r_status <= ST_OK;
                    r_qi     <= {1'b0, r_q} + {{SIG_WIDTH{1'b0}}, inc};
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_ostat <= r_status;
                    if (r_status == ST_OK) begin
                        r_osig   <= 64'(signed'(sig_w));
                        r_oscale <= r_t;
                    end else begin
                        r_osig   <= '0;
                        r_oscale <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {6'd0, r_ostat, r_oscale, r_osig};

    // An error result carries neither a significand nor a scale.
    `DDR_ASSERT_NOW(a_err_zero, r_ov && r_ostat != ST_OK, {r_osig, r_oscale} == '0, "error not zeroed")
    // The shared divider is never restarted while a pass is under way.
    `DDR_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider started while busy")
    // An accepted item always goes to the operand check next.
    `DDR_ASSERT_NEXT(a_accept_check, in_acc, r_state == S_CHECK, "accept not followed by check")
    // Every result carries a scale inside the clamped range.
    `DDR_ASSERT_NOW(a_scale_range, r_ov, r_oscale <= RMAX && r_oscale >= -RMAX, "scale out of range")

endmodule
